// File: design/nq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nq_pkg;

  // Field widths and the largest board the output fields can describe.
  localparam int ROW_W     = 4;
  localparam int BSZ_W     = 5;
  localparam int SIZE_CAP  = 16;
  localparam logic [BSZ_W-1:0] BSZ_RESET = 5'd8;

  // One bit per row of the board.
  typedef logic [SIZE_CAP-1:0] nq_rows_t;

  // Attack masks seen by one column, already shifted to that column.
  typedef struct packed {
    nq_rows_t row;
    nq_rows_t down;
    nq_rows_t up;
  } nq_masks_t;

  // Outcome of one evaluation step of the active cell.
  typedef struct packed {
    logic place;
    logic fail;
  } nq_stat_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } nq_state_t;

endpackage

`default_nettype wire

// File: design/nq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module nq_cell (
  input  wire logic              clk,
  input  wire logic              load_zero,
  input  wire logic              load_left,
  input  wire nq_pkg::nq_masks_t left_masks,
  input  wire logic              active,
  input  wire nq_pkg::nq_rows_t  size_mask,
  output nq_pkg::nq_stat_t       stat,
  output logic [3:0]             qrow,
  output nq_pkg::nq_masks_t      right_masks
);
  import nq_pkg::*;

  nq_masks_t        masks;
  logic [BSZ_W-1:0] next_try;
  nq_rows_t         ge_mask;
  nq_rows_t         free_rows;
  nq_rows_t         qbit;
  logic [ROW_W-1:0] pick;
  logic             hit;

  // Rows still open in this column at or above the next row to try.
  always_comb begin
    ge_mask   = {SIZE_CAP{1'b1}} << next_try;
    free_rows = ~(masks.row | masks.down | masks.up) & size_mask & ge_mask;
    hit       = |free_rows;
    pick      = '0;
    for (int i = SIZE_CAP - 1; i >= 0; i--) begin
      if (free_rows[i]) begin
        pick = ROW_W'(i);
      end
    end
  end

  assign stat.place = active & hit;
  assign stat.fail  = active & ~hit;

  // Masks for the next column, taken in the cycle this cell places its queen.
  // The diagonals move one row per column.
  always_comb begin
    qbit             = nq_rows_t'(1) << pick;
    right_masks.row  = masks.row | qbit;
    right_masks.down = (masks.down | qbit) << 1;
    right_masks.up   = (masks.up | qbit) >> 1;
  end

  // A fresh load restarts at row zero; a placement resumes above its row on backtrack.
  always_ff @(posedge clk) begin
    if (load_zero) begin
      masks    <= '0;
      next_try <= '0;
    end else if (load_left) begin
      masks    <= left_masks;
      next_try <= '0;
    end else if (active && hit) begin
      qrow     <= pick;
      next_try <= BSZ_W'(pick) + BSZ_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: design/nq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nq_ctrl #(
  parameter int NCELL = 16,
  parameter int PW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [4:0]       start_column,
  input  wire logic             cfg_we,
  input  wire logic [4:0]       cfg_wdata,
  input  wire nq_pkg::nq_stat_t sel_stat,
  input  wire logic [3:0]       sel_row,
  output logic                  busy,
  output logic                  searching,
  output logic                  load_start,
  output logic [PW-1:0]         ptr,
  output logic [4:0]            eff_size,
  output logic                  strobe,
  output logic [3:0]            column,
  output logic [3:0]            row,
  output logic                  found,
  output logic                  has_placement,
  output logic                  last
);
  import nq_pkg::*;

  nq_state_t        state;
  logic [BSZ_W-1:0] board_size;
  logic [PW-1:0]    start_col;
  logic             at_last;
  logic             start_ok;

  // Board size register; eff_size caps its value at the number of cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= BSZ_RESET;
    end else if (cfg_we) begin
      board_size <= cfg_wdata;
    end
  end

  assign eff_size   = (board_size > BSZ_W'(NCELL)) ? BSZ_W'(NCELL) : board_size;
  assign start_ok   = start_column < eff_size;
  assign busy       = (state != ST_IDLE);
  assign searching  = (state == ST_SEARCH);
  assign load_start = (state == ST_IDLE) && start && start_ok;
  assign at_last    = (BSZ_W'(ptr) + BSZ_W'(1)) == eff_size;

  // Result strobe: high for one cycle with each word the sequencer puts out.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ((state == ST_IDLE) && start && !start_ok) ||
                ((state == ST_SEARCH) && sel_stat.fail && (ptr == start_col)) ||
                (state == ST_EMIT);
    end
  end

  // Search sequencer: one place or backtrack step per cycle, then one result per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ptr    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (start_ok) begin
              state     <= ST_SEARCH;
              ptr       <= start_column[PW-1:0];
              start_col <= start_column[PW-1:0];
            end else begin
              column        <= '0;
              row           <= '0;
              found         <= 1'b1;
              has_placement <= 1'b0;
              last          <= 1'b1;
            end
          end
        end
        ST_SEARCH: begin
          if (sel_stat.place) begin
            if (at_last) begin
              state <= ST_EMIT;
              ptr   <= start_col;
            end else begin
              ptr <= ptr + PW'(1);
            end
          end else if (sel_stat.fail) begin
            if (ptr == start_col) begin
              state         <= ST_IDLE;
              column        <= '0;
              row           <= '0;
              found         <= 1'b0;
              has_placement <= 1'b0;
              last          <= 1'b1;
            end else begin
              ptr <= ptr - PW'(1);
            end
          end
        end
        ST_EMIT: begin
          column        <= ROW_W'(ptr);
          row           <= sel_row;
          found         <= 1'b1;
          has_placement <= 1'b1;
          last          <= at_last;
          if (at_last) begin
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + PW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/n_queens_backtrack_solver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Word
// request   start, busy               start_column
// config    cfg_we                    cfg_wdata (board size)
// result    strobe                    column, row, found, has_placement, last
//
// A request is taken when start is high and busy is low. The search goes step
// by step, a step being one placement or one backtrack, decided by the
// free-row check of the single active column cell. A solved board then shows
// one word per placed column, one word per cycle; a board with no solution
// shows a single word, and so does a start column past the board, with busy
// staying low. A new request can be taken while the last word is shown.
// rst is synchronous and clears the sequencer and the board size (to 8); the
// column cells need no clearing. The receiver cannot stall results.

module n_queens_backtrack_solver_top #(
  parameter int MAX_N = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [4:0] start_column,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  output logic            strobe,
  output logic [3:0]      column,
  output logic [3:0]      row,
  output logic            found,
  output logic            has_placement,
  output logic            last
);
  import nq_pkg::*;

  localparam int NCELL = (MAX_N < SIZE_CAP) ? MAX_N : SIZE_CAP;
  localparam int PW    = $clog2(NCELL);

  logic             searching;
  logic             load_start;
  logic [PW-1:0]    ptr;
  logic [BSZ_W-1:0] eff_size;
  nq_rows_t         size_mask;
  nq_stat_t         sel_stat;
  logic [3:0]       sel_row;
  logic [NCELL-1:0] active;
  nq_stat_t         stat [NCELL];
  logic [3:0]       qrow [NCELL];
  nq_masks_t        masks_out [NCELL];

  // Rows that lie on the board.
  always_comb begin
    for (int i = 0; i < SIZE_CAP; i++) begin
      size_mask[i] = BSZ_W'(i) < eff_size;
    end
  end

  // Chain of column cells; each passes its attack masks to the right.
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    logic      load_zero;
    logic      load_left;
    nq_masks_t left_masks;

    assign active[c]  = searching && (ptr == PW'(c));
    assign load_zero  = load_start && (start_column == BSZ_W'(c));
    if (c == 0) begin : g_first
      assign load_left  = 1'b0;
      assign left_masks = '0;
    end else begin : g_rest
      assign load_left  = stat[c-1].place;
      assign left_masks = masks_out[c-1];
    end

    nq_cell u_cell (
      .clk         (clk),
      .load_zero   (load_zero),
      .load_left   (load_left),
      .left_masks  (left_masks),
      .active      (active[c]),
      .size_mask   (size_mask),
      .stat        (stat[c]),
      .qrow        (qrow[c]),
      .right_masks (masks_out[c])
    );
  end

  // Only the active cell reports, so the outcomes can be merged by OR.
  always_comb begin
    sel_stat = '0;
    for (int i = 0; i < NCELL; i++) begin
      sel_stat = sel_stat | stat[i];
    end
  end

  assign sel_row = qrow[ptr];

  nq_ctrl #(
    .NCELL (NCELL),
    .PW    (PW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .start_column  (start_column),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .sel_stat      (sel_stat),
    .sel_row       (sel_row),
    .busy          (busy),
    .searching     (searching),
    .load_start    (load_start),
    .ptr           (ptr),
    .eff_size      (eff_size),
    .strobe        (strobe),
    .column        (column),
    .row           (row),
    .found         (found),
    .has_placement (has_placement),
    .last          (last)
  );

  // At most one column cell evaluates at a time.
  a_one_active: assert property (@(posedge clk) disable iff (rst) $onehot0(active))
    else $error("more than one column cell active");

  // A result with a queen always belongs to a found solution.
  a_place_found: assert property (@(posedge clk) disable iff (rst)
    strobe && has_placement |-> found)
    else $error("placement reported without a solution");

  // A result without a queen is the only result of its request.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_placement |-> last)
    else $error("empty result not marked last");

  // The final result of a request leaves the block free for the next request.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("block still busy after final result");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import nq_pkg::*;

  localparam int MAX_N        = 16;
  localparam int DIAG_BIAS    = 15;
  localparam int CYCLE_LIMIT  = 50_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_END   = 20;

  // One result word as the block presents it.
  typedef struct packed {
    logic [ROW_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             found;
    logic             has_placement;
    logic             last;
  } placement_t;

  // Kinds of row in the directed stimulus table.
  typedef enum logic {
    ROW_REQUEST,
    ROW_SIZE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [4:0] value;
    logic       typed;
    placement_t want;
  } stim_row_t;

  // Words that need no search to predict.
  localparam placement_t PAST_BOARD  = {4'd0, 4'd0, 1'b1, 1'b0, 1'b1};
  localparam placement_t NO_SOLUTION = {4'd0, 4'd0, 1'b0, 1'b0, 1'b1};

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [4:0] start_column;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  logic       strobe;
  logic [3:0] column;
  logic [3:0] row;
  logic       found;
  logic       has_placement;
  logic       last;

  // Shadow copy of the board size register and of the search state.
  logic [4:0]  board_size_set;
  logic [3:0]  queen_rows [MAX_N];
  logic [15:0] rows_taken;
  logic [30:0] down_taken;
  logic [30:0] up_taken;

  placement_t expected_placements [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         idle_on;

  n_queens_backtrack_solver_top #(
    .MAX_N(MAX_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_column(start_column),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .strobe(strobe),
    .column(column),
    .row(row),
    .found(found),
    .has_placement(has_placement),
    .last(last)
  );

  always #2 clk = ~clk;

  // Board edge after capping the register at the largest describable board.
  function automatic int board_edge();
    int n;
    n = int'(board_size_set);
    if (n > MAX_N) n = MAX_N;
    if (n > SIZE_CAP) n = SIZE_CAP;
    return n;
  endfunction

  function automatic bit cell_open(int r, int c);
    return !rows_taken[r] && !down_taken[r + DIAG_BIAS - c] && !up_taken[r + c];
  endfunction

  function automatic void set_cell(int r, int c, bit v);
    rows_taken[r] = v;
    down_taken[r + DIAG_BIAS - c] = v;
    up_taken[r + c] = v;
  endfunction

  function automatic placement_t single_queen(logic [3:0] col);
    return {col, 4'd0, 1'b1, 1'b1, 1'b1};
  endfunction

  // Append one word to the list of words still to come.
  function automatic void expect_word(placement_t w);
    expected_placements.insert(expected_placements.size(), w);
  endfunction

  // Depth-first search, lowest free row first, queuing the words it implies.
  function automatic void plan_queens(input logic [4:0] first_col);
    int         n;
    int         col;
    int         r;
    int         k;
    bit         solved;
    placement_t p;
    n = board_edge();
    rows_taken = '0;
    down_taken = '0;
    up_taken = '0;
    solved = 1'b0;
    if (first_col >= n) begin
      expect_word(PAST_BOARD);
      return;
    end
    col = int'(first_col);
    r = 0;
    while (1) begin
      while (r < n && !cell_open(r, col)) r++;
      if (r < n) begin
        queen_rows[col] = r[3:0];
        set_cell(r, col, 1'b1);
        col++;
        if (col >= n) begin
          solved = 1'b1;
          break;
        end
        r = 0;
      end else begin
        // Column exhausted: step back and retry the previous column.
        if (col == first_col) break;
        col--;
        r = int'(queen_rows[col]);
        set_cell(r, col, 1'b0);
        r++;
      end
    end
    if (!solved) begin
      expect_word(NO_SOLUTION);
      return;
    end
    for (k = int'(first_col); k < n; k++) begin
      p.column = k[3:0];
      p.row = queen_rows[k];
      p.found = 1'b1;
      p.has_placement = 1'b1;
      p.last = (k == n - 1);
      expect_word(p);
    end
  endfunction

  function automatic void add_row(row_kind_t kind, logic [4:0] value, logic typed,
                                  placement_t want);
    stim_row_t s;
    s.kind = kind;
    s.value = value;
    s.typed = typed;
    s.want = want;
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  // Compare every result word against the oldest expectation.
  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (!rst && strobe === 1'b1) begin
      got = {column, row, found, has_placement, last};
      if (expected_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected word: column %0d row %0d found %0b placed %0b last %0b",
                   got.column, got.row, got.found, got.has_placement, got.last);
      end else begin
        want = expected_placements.pop_front();
        if (got.column !== want.column || got.row !== want.row ||
            got.found !== want.found || got.has_placement !== want.has_placement ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch: expected column %0d row %0d found %0b placed %0b last %0b,",
                     want.column, want.row, want.found, want.has_placement, want.last,
                     " got column %0d row %0d found %0b placed %0b last %0b",
                     got.column, got.row, got.found, got.has_placement, got.last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // A random burst of idle cycles on the request side.
  task automatic idle_burst();
    int gap;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 15);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold requests back until every expected word has come and the block is idle.
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (expected_placements.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_board_size(input logic [4:0] value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    board_size_set = value;
  endtask

  // Present one request word and record what it should produce once taken.
  task automatic send_request(input logic [4:0] value, input logic typed,
                              input placement_t want);
    idle_burst();
    @(negedge clk);
    start <= 1'b1;
    start_column <= value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (typed) expect_word(want);
    else plan_queens(value);
  endtask

  initial begin
    int         i;
    int         phase;
    int         pick;
    int         n;
    logic [4:0] size;
    logic [4:0] first_col;

    rst = 1'b1;
    start = 1'b0;
    start_column = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    board_size_set = BSZ_RESET;

    // Directed table: reset size, extremes of the start column, the empty
    // board, boards with no solution, and a register value beyond the cap.
    add_row(ROW_REQUEST, 5'd0, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd7, 1'b1, single_queen(4'd7));
    add_row(ROW_REQUEST, 5'd8, 1'b1, PAST_BOARD);
    add_row(ROW_REQUEST, 5'd31, 1'b1, PAST_BOARD);
    add_row(ROW_REQUEST, 5'd16, 1'b1, PAST_BOARD);
    add_row(ROW_SIZE, 5'd0, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b1, PAST_BOARD);
    add_row(ROW_REQUEST, 5'd5, 1'b1, PAST_BOARD);
    add_row(ROW_SIZE, 5'd1, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b1, single_queen(4'd0));
    add_row(ROW_REQUEST, 5'd1, 1'b1, PAST_BOARD);
    add_row(ROW_SIZE, 5'd2, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b1, NO_SOLUTION);
    add_row(ROW_REQUEST, 5'd1, 1'b1, single_queen(4'd1));
    add_row(ROW_SIZE, 5'd3, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b1, NO_SOLUTION);
    add_row(ROW_REQUEST, 5'd1, 1'b0, '0);
    add_row(ROW_SIZE, 5'd4, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd2, 1'b0, '0);
    add_row(ROW_SIZE, 5'd16, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd15, 1'b1, single_queen(4'd15));
    add_row(ROW_REQUEST, 5'd16, 1'b1, PAST_BOARD);
    add_row(ROW_SIZE, 5'd31, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd16, 1'b1, PAST_BOARD);
    add_row(ROW_REQUEST, 5'd15, 1'b1, single_queen(4'd15));
    add_row(ROW_REQUEST, 5'd10, 1'b0, '0);
    add_row(ROW_SIZE, 5'd5, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd0, 1'b0, '0);
    add_row(ROW_REQUEST, 5'd3, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SIZE) write_board_size(directed_rows[i].value);
      else send_request(directed_rows[i].value, directed_rows[i].typed,
                        directed_rows[i].want);
    end

    // Random phases: mostly small boards, now and then one near the cap.
    for (phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) size = 5'd0;
      else if (pick < 70) size = 5'($urandom_range(1, 10));
      else if (pick < 90) size = 5'($urandom_range(11, 13));
      else size = 5'($urandom_range(14, 31));
      write_board_size(size);
      if (phase == 7) idle_on = 1'b0;
      for (i = 0; i < 12; i++) begin
        if ($urandom_range(0, 11) == 0) drain();
        n = board_edge();
        if (n > 0 && $urandom_range(0, 99) < 85) first_col = 5'($urandom_range(0, n - 1));
        else first_col = 5'($urandom_range(0, 31));
        send_request(first_col, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_END) @(posedge clk);
    if (mismatch_count == 0 && expected_placements.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
